@@ rtl/cft_pkg.sv @@
// Shared types, codes and constants of the CSV field tokenizer.
package cft_pkg;

	typedef logic [7:0] byte_t;
	typedef logic [1:0] req_type_t;
	typedef logic [1:0] kind_t;
	typedef logic [0:0] cfg_idx_t;
	typedef logic [1:0] line_pos_t;
	typedef logic [1:0] res_cnt_t;

	// request types
	localparam req_type_t REQ_CHAR = 2'd0;
	localparam req_type_t REQ_EOL  = 2'd1;
	localparam req_type_t REQ_EOI  = 2'd2;

	// result kinds
	localparam kind_t KIND_CHAR       = 2'd0;
	localparam kind_t KIND_FIELD_END  = 2'd1;
	localparam kind_t KIND_RECORD_END = 2'd2;
	localparam kind_t KIND_NO_RECORD  = 2'd3;

	// configuration register indexes
	localparam cfg_idx_t CFG_SEPARATOR = 1'd0;
	localparam cfg_idx_t CFG_QUOTE     = 1'd1;

	localparam byte_t SEP_RESET   = 8'd44;
	localparam byte_t QUOTE_RESET = 8'd34;
	localparam byte_t NL_BYTE     = 8'd10;

	// line position saturates here
	localparam line_pos_t LINE_POS_MAX = 2'd3;

	typedef struct packed {
		kind_t kind;
		byte_t data;
		logic  last;
	} res_t;

endpackage

@@ rtl/cft_req_if.sv @@
// Request channel: one character, line end or end of input.
interface cft_req_if;
	import cft_pkg::*;

	logic      valid;
	logic      ready;
	req_type_t req_type;
	byte_t     char_byte;

	modport source (output valid, output req_type, output char_byte, input ready);
	modport sink (input valid, input req_type, input char_byte, output ready);
endinterface

@@ rtl/cft_res_if.sv @@
// Result channel: field characters, field ends, record ends and no-record marks.
interface cft_res_if;
	import cft_pkg::*;

	logic  valid;
	logic  ready;
	kind_t out_kind;
	byte_t out_byte;
	logic  last;

	modport source (output valid, output out_kind, output out_byte, output last, input ready);
	modport sink (input valid, input out_kind, input out_byte, input last, output ready);
endinterface

@@ rtl/csv_field_tokenizer_top.sv @@
// CSV field tokenizer: quote-aware field and record splitter, one request per cycle at most.
// Latency: a result is valid in the cycle after its request is accepted.
// Throughput: one request per cycle while each request yields one result and results are
// taken; a request with two results holds the next request off (two-entry result buffer).
// Reset (arst_n low): parser state cleared, separator back to comma, quote to double quote.
// Requests are taken only when the result buffer is empty after this cycle's pop.
module csv_field_tokenizer_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  cft_pkg::cfg_idx_t  cfg_idx,
	input  cft_pkg::byte_t     cfg_data,
	cft_req_if.sink            req,
	cft_res_if.source          res
);
	import cft_pkg::*;

	// configuration
	byte_t sep_q, quote_q;

	// parser state
	logic      in_quotes_q, pending_q, doubled_q, pos_ok_q, record_open_q;
	byte_t     pend_prev_q, prev_q;
	line_pos_t line_pos_q;

	logic      in_quotes_d, pending_d, doubled_d, pos_ok_d, record_open_d;
	byte_t     pend_prev_d, prev_d;
	line_pos_t line_pos_d;

	// result buffer
	res_t     slot0_q, slot1_q;
	res_cnt_t cnt_q;

	// step logic outputs
	res_t     r0, r1;
	res_cnt_t n_res;
	logic     iq, keep, m_v;
	kind_t    m_kind;
	byte_t    m_data;

	logic acc, pop;

	// handshake
	assign pop       = res.valid && res.ready;
	assign req.ready = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && res.ready);
	assign acc       = req.valid && req.ready;

	assign res.valid    = (cnt_q != 2'd0);
	assign res.out_kind = slot0_q.kind;
	assign res.out_byte = slot0_q.data;
	assign res.last     = slot0_q.last;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q   <= SEP_RESET;
			quote_q <= QUOTE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_SEPARATOR: sep_q   <= cfg_data;
				CFG_QUOTE:     quote_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// one request: settle a held quote, then handle the request itself
	always_comb begin
		in_quotes_d   = in_quotes_q;
		pending_d     = pending_q;
		doubled_d     = doubled_q;
		pos_ok_d      = pos_ok_q;
		record_open_d = record_open_q;
		pend_prev_d   = pend_prev_q;
		prev_d        = prev_q;
		line_pos_d    = line_pos_q;
		r0            = '0;
		r1            = '0;
		n_res         = 2'd0;
		m_v           = 1'b0;
		m_kind        = KIND_CHAR;
		m_data        = '0;
		// a held quote toggles quoted mode unless it turns out doubled
		iq            = pending_q ? !in_quotes_q : in_quotes_q;
		keep          = pending_q && pos_ok_q && (pend_prev_q != sep_q) &&
		                (req.char_byte != sep_q);

		unique case (req.req_type)
			REQ_CHAR: begin
				prev_d     = req.char_byte;
				line_pos_d = (line_pos_q == LINE_POS_MAX) ? line_pos_q : line_pos_q + 2'd1;
				pending_d  = 1'b0;
				if (pending_q && doubled_q && (req.char_byte == quote_q)) begin
					// doubled quote inside quotes: one literal quote
					r0    = '{kind: KIND_CHAR, data: quote_q, last: 1'b1};
					n_res = 2'd1;
				end else begin
					in_quotes_d   = iq;
					record_open_d = 1'b1;
					if (req.char_byte == quote_q) begin
						// hold the quote until the next character is seen
						pending_d   = 1'b1;
						doubled_d   = iq;
						pos_ok_d    = (line_pos_q == LINE_POS_MAX);
						pend_prev_d = prev_q;
					end else if ((req.char_byte == sep_q) && !iq) begin
						m_v    = 1'b1;
						m_kind = KIND_FIELD_END;
					end else begin
						m_v    = 1'b1;
						m_data = req.char_byte;
					end
					if (keep) begin
						r0    = '{kind: KIND_CHAR, data: quote_q, last: !m_v};
						r1    = '{kind: m_kind, data: m_data, last: 1'b1};
						n_res = m_v ? 2'd2 : 2'd1;
					end else begin
						r0    = '{kind: m_kind, data: m_data, last: 1'b1};
						n_res = m_v ? 2'd1 : 2'd0;
					end
				end
			end
			REQ_EOL: begin
				pending_d   = 1'b0;
				in_quotes_d = iq;
				line_pos_d  = '0;
				prev_d      = '0;
				n_res       = 2'd1;
				if (iq) begin
					r0 = '{kind: KIND_CHAR, data: NL_BYTE, last: 1'b1};
				end else if (record_open_q) begin
					r0            = '{kind: KIND_RECORD_END, data: '0, last: 1'b1};
					record_open_d = 1'b0;
				end else begin
					r0 = '{kind: KIND_NO_RECORD, data: '0, last: 1'b1};
				end
			end
			REQ_EOI: begin
				in_quotes_d   = 1'b0;
				pending_d     = 1'b0;
				doubled_d     = 1'b0;
				pos_ok_d      = 1'b0;
				pend_prev_d   = '0;
				line_pos_d    = '0;
				prev_d        = '0;
				record_open_d = 1'b0;
				n_res         = 2'd1;
				if (iq && (line_pos_q != 2'd0)) begin
					r0    = '{kind: KIND_CHAR, data: NL_BYTE, last: 1'b0};
					r1    = '{kind: KIND_RECORD_END, data: '0, last: 1'b1};
					n_res = 2'd2;
				end else if (iq || record_open_q) begin
					r0 = '{kind: KIND_RECORD_END, data: '0, last: 1'b1};
				end else begin
					r0 = '{kind: KIND_NO_RECORD, data: '0, last: 1'b1};
				end
			end
			default: ; // unused type: ignored
		endcase
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_quotes_q   <= 1'b0;
			pending_q     <= 1'b0;
			doubled_q     <= 1'b0;
			pos_ok_q      <= 1'b0;
			record_open_q <= 1'b0;
			pend_prev_q   <= '0;
			prev_q        <= '0;
			line_pos_q    <= '0;
		end else if (acc) begin
			in_quotes_q   <= in_quotes_d;
			pending_q     <= pending_d;
			doubled_q     <= doubled_d;
			pos_ok_q      <= pos_ok_d;
			record_open_q <= record_open_d;
			pend_prev_q   <= pend_prev_d;
			prev_q        <= prev_d;
			line_pos_q    <= line_pos_d;
		end
	end

	// result buffer fill count; buffer is empty after pop whenever a request is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (acc) begin
			cnt_q <= n_res;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// result buffer payload
	always_ff @(posedge clk) begin
		if (acc) begin
			slot0_q <= r0;
			slot1_q <= r1;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

	// a result that is not last always has its follower buffered
	a_last_pair: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !slot0_q.last |-> cnt_q == 2'd2)
		else $error("non-last result without a following result");

	// a held quote always belongs to an open record
	a_pend_open: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q |-> record_open_q)
		else $error("quote held with no open record");

	// end of input returns the parser to its reset state
	a_eoi_clear: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (req.req_type == REQ_EOI) |=>
		!in_quotes_q && !pending_q && !record_open_q && (line_pos_q == 2'd0))
		else $error("parser state not cleared after end of input");

endmodule

@@ dv/cft_checker.sv @@
// Tokenizer checker: tracks requests, config writes and results, predicts and compares.
module cft_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  cft_pkg::cfg_idx_t cfg_idx,
	input  cft_pkg::byte_t    cfg_data,
	cft_req_if                req,
	cft_res_if                res,
	output int                fail_count,
	output int                outstanding
);
	import cft_pkg::*;

	// register copies
	byte_t sep_byte;
	byte_t quote_byte;

	// parser state
	logic      quoted;
	logic      held_quote;
	logic      held_in_quotes;
	logic      held_deep_enough;
	byte_t     held_prior;
	line_pos_t col;
	byte_t     last_char;
	logic      record_started;

	res_t step_tokens[$];
	res_t expected_tokens[$];

	task automatic report_mismatch(input string what);
		$display("[%0t] token mismatch: %s", $realtime, what);
		fail_count++;
	endtask

	task automatic push_token(input kind_t k, input byte_t b);
		res_t t;
		t.kind = k;
		t.data = b;
		t.last = 1'b0;
		step_tokens = {step_tokens, t};
	endtask

	task automatic note_char(input byte_t c);
		last_char = c;
		if (col < LINE_POS_MAX)
			col = col + 1'b1;
	endtask

	task automatic clear_parser();
		quoted           = 1'b0;
		held_quote       = 1'b0;
		held_in_quotes   = 1'b0;
		held_deep_enough = 1'b0;
		held_prior       = '0;
		col              = '0;
		last_char        = '0;
		record_started   = 1'b0;
	endtask

	// Settle a held quote against what follows; used=1 when a doubled quote ate c.
	task automatic settle_quote(input logic have_char, input byte_t c, output logic used);
		used = 1'b0;
		if (held_quote) begin
			held_quote = 1'b0;
			if (held_in_quotes && have_char && c == quote_byte) begin
				push_token(KIND_CHAR, quote_byte);
				note_char(c);
				used = 1'b1;
			end else begin
				quoted = !quoted;
				// quote kept as text when embedded mid-field, away from separators
				if (held_deep_enough && held_prior != sep_byte && have_char && c != sep_byte)
					push_token(KIND_CHAR, quote_byte);
			end
		end
	endtask

	// Work out the tokens of one request and queue them up.
	task automatic tokenize_request(input req_type_t t, input byte_t c);
		logic used;
		res_t tok;
		step_tokens.delete();
		case (t)
			REQ_CHAR: begin
				settle_quote(1'b1, c, used);
				if (!used) begin
					record_started = 1'b1;
					if (c == quote_byte) begin
						held_quote       = 1'b1;
						held_in_quotes   = quoted;
						held_deep_enough = (col >= LINE_POS_MAX);
						held_prior       = last_char;
					end else if (c == sep_byte && !quoted) begin
						push_token(KIND_FIELD_END, '0);
					end else begin
						push_token(KIND_CHAR, c);
					end
					note_char(c);
				end
			end
			REQ_EOL: begin
				settle_quote(1'b0, '0, used);
				if (quoted) begin
					push_token(KIND_CHAR, NL_BYTE);
				end else if (record_started) begin
					push_token(KIND_RECORD_END, '0);
					record_started = 1'b0;
				end else begin
					push_token(KIND_NO_RECORD, '0);
				end
				col       = '0;
				last_char = '0;
			end
			REQ_EOI: begin
				settle_quote(1'b0, '0, used);
				if (quoted) begin
					if (col != 0)
						push_token(KIND_CHAR, NL_BYTE);
					push_token(KIND_RECORD_END, '0);
				end else if (record_started) begin
					push_token(KIND_RECORD_END, '0);
				end else begin
					push_token(KIND_NO_RECORD, '0);
				end
				clear_parser();
			end
			default: ; // unused request type: no token, no state change
		endcase
		foreach (step_tokens[i]) begin
			tok      = step_tokens[i];
			tok.last = (i == step_tokens.size() - 1);
			expected_tokens = {expected_tokens, tok};
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			sep_byte   = SEP_RESET;
			quote_byte = QUOTE_RESET;
			clear_parser();
			expected_tokens.delete();
			fail_count  = 0;
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == CFG_SEPARATOR)
					sep_byte = cfg_data;
				else if (cfg_idx == CFG_QUOTE)
					quote_byte = cfg_data;
			end

			// results: compare against the oldest expectation
			if (res.valid && res.ready) begin
				if (expected_tokens.size() == 0) begin
					report_mismatch($sformatf("unexpected token kind %0d byte %02h last %0b",
						res.out_kind, res.out_byte, res.last));
				end else begin
					want = expected_tokens.pop_front();
					if (res.out_kind !== want.kind)
						report_mismatch($sformatf("kind %0d, expected %0d",
							res.out_kind, want.kind));
					if (res.out_byte !== want.data)
						report_mismatch($sformatf("byte %02h, expected %02h",
							res.out_byte, want.data));
					if (res.last !== want.last)
						report_mismatch($sformatf("last %0b, expected %0b",
							res.last, want.last));
				end
			end

			if (req.valid && req.ready)
				tokenize_request(req.req_type, req.char_byte);

			outstanding = expected_tokens.size();
		end
	end

endmodule

@@ dv/tb_csv_field_tokenizer_top.sv @@
// Testbench top: clock, reset, request and config stimulus, result back-pressure, verdict.
module tb_csv_field_tokenizer_top;
	import cft_pkg::*;

	localparam req_type_t REQ_UNUSED   = 2'd3;
	localparam int        NUM_PHASES   = 6;
	localparam int        PHASE_ITEMS  = 305;
	localparam int        IDLE_PCT     = 21;
	localparam int        LONG_HOLD    = 80;
	localparam int        SETTLE_CYCLES = 4;
	localparam int        DRAIN_CYCLES = 20;
	localparam int        QUIET_LIMIT  = 5000;

	// separator and quote per phase; phase 0 runs on reset values
	localparam byte_t PHASE_SEP   [NUM_PHASES] = '{8'd44, 8'h00, 8'hFF, 8'h3B, 8'h7C, 8'd44};
	localparam byte_t PHASE_QUOTE [NUM_PHASES] = '{8'd34, 8'hFF, 8'h00, 8'h27, 8'h7C, 8'd34};

	logic     clk;
	logic     arst_n;
	logic     cfg_we;
	cfg_idx_t cfg_idx;
	byte_t    cfg_data;

	int    fail_count;
	int    outstanding;
	int    src_idle_pct;
	int    snk_idle_pct;
	int    hold_requests;
	int    sent_items;
	byte_t sep_now;
	byte_t quote_now;

	cft_req_if req_ch();
	cft_res_if res_ch();

	csv_field_tokenizer_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.req      (req_ch),
		.res      (res_ch)
	);

	cft_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data),
		.req         (req_ch),
		.res         (res_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one request, idling at random first; returns once it is taken.
	task automatic send_req(input req_type_t t, input byte_t c);
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.req_type  <= t;
		req_ch.char_byte <= c;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		if (t != REQ_UNUSED)
			sent_items++;
	endtask

	// Stop offering and wait for every expected token.
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
	endtask

	task automatic write_config(input byte_t sep, input byte_t quote);
		drain_results();
		// a held quote yields nothing yet, so give the block a few more cycles
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= CFG_SEPARATOR;
		cfg_data <= sep;
		@(posedge clk);
		cfg_idx  <= CFG_QUOTE;
		cfg_data <= quote;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		sep_now   = sep;
		quote_now = quote;
	endtask

	function automatic byte_t text_byte();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return byte_t'("a" + $urandom_range(25));
		else if (r < 75)
			return byte_t'("0" + $urandom_range(9));
		else
			return byte_t'($urandom_range(255));
	endfunction

	// Record: quoted and plain fields, stray quotes too, ended by line end or end of input.
	task automatic send_record();
		int fields;
		int len;
		int r;
		fields = $urandom_range(1, 4);
		for (int f = 0; f < fields; f++) begin
			if ($urandom_range(2) == 0) begin
				send_req(REQ_CHAR, quote_now);
				len = $urandom_range(0, 5);
				for (int i = 0; i < len; i++) begin
					r = $urandom_range(99);
					if (r < 12) begin
						send_req(REQ_CHAR, quote_now);
						send_req(REQ_CHAR, quote_now);
					end else if (r < 22) begin
						send_req(REQ_CHAR, sep_now);
					end else if (r < 27) begin
						send_req(REQ_EOL, text_byte());
					end else begin
						send_req(REQ_CHAR, text_byte());
					end
				end
				send_req(REQ_CHAR, quote_now);
			end else begin
				len = $urandom_range(0, 6);
				for (int i = 0; i < len; i++) begin
					// stray quotes inside plain text
					if ($urandom_range(99) < 10)
						send_req(REQ_CHAR, quote_now);
					else
						send_req(REQ_CHAR, text_byte());
				end
			end
			if (f < fields - 1)
				send_req(REQ_CHAR, sep_now);
		end
		r = $urandom_range(99);
		if (r < 10) begin
			send_req(REQ_EOI, text_byte());
		end else begin
			send_req(REQ_EOL, text_byte());
			if (r < 16)
				send_req(REQ_EOL, text_byte());
		end
	endtask

	// Directed requests on the reset separator and quote.
	task automatic run_directed();
		send_req(REQ_CHAR, 8'h00);
		send_req(REQ_CHAR, 8'hFF);
		send_req(REQ_CHAR, ",");
		// quote opens after a separator, doubled quote, separator and line end inside
		send_req(REQ_CHAR, "\"");
		send_req(REQ_CHAR, "b");
		send_req(REQ_CHAR, "\"");
		send_req(REQ_CHAR, "\"");
		send_req(REQ_CHAR, ",");
		send_req(REQ_EOL, 8'hFF);
		// held quote then line end closes quotes, then an empty line
		send_req(REQ_CHAR, "\"");
		send_req(REQ_EOL, 8'h00);
		send_req(REQ_EOL, 8'hA5);
		// embedded quote kept as text
		send_req(REQ_CHAR, "a");
		send_req(REQ_CHAR, "b");
		send_req(REQ_CHAR, "c");
		send_req(REQ_CHAR, "\"");
		send_req(REQ_CHAR, "d");
		// held quote then end of input; end of input on an empty record
		send_req(REQ_CHAR, "\"");
		send_req(REQ_EOI, 8'h5A);
		send_req(REQ_EOI, 8'h00);
		send_req(REQ_UNUSED, 8'hFF);
		// end of input inside quotes, with and without text on the line
		send_req(REQ_CHAR, "\"");
		send_req(REQ_CHAR, "x");
		send_req(REQ_EOI, 8'h00);
		send_req(REQ_CHAR, "\"");
		send_req(REQ_EOL, 8'h00);
		send_req(REQ_EOI, 8'h00);
	endtask

	// Result side back-pressure, with long holds on demand.
	initial begin
		int holds_served;
		holds_served = 0;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_requests != holds_served) begin
				res_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				holds_served++;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	// Watchdog: too long without any request or result taken.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("simulation failed");
		$finish;
	end

	// Main stimulus and verdict.
	initial begin
		int target;
		int midpoint;
		logic mid_done;
		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_idx          <= CFG_SEPARATOR;
		cfg_data         <= '0;
		req_ch.valid     <= 1'b0;
		req_ch.req_type  <= REQ_CHAR;
		req_ch.char_byte <= '0;
		src_idle_pct  = IDLE_PCT;
		snk_idle_pct  = IDLE_PCT;
		hold_requests = 0;
		sent_items    = 0;
		sep_now       = SEP_RESET;
		quote_now     = QUOTE_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p > 0)
				write_config(PHASE_SEP[p], PHASE_QUOTE[p]);
			// phase 2 runs with no idling on either side
			src_idle_pct = (p == 2) ? 0 : IDLE_PCT;
			snk_idle_pct = (p == 2) ? 0 : IDLE_PCT;
			target   = sent_items + PHASE_ITEMS;
			midpoint = sent_items + PHASE_ITEMS / 2;
			mid_done = 1'b0;
			while (sent_items < target) begin
				if (!mid_done && sent_items >= midpoint) begin
					mid_done = 1'b1;
					// result side holds off while requests keep coming
					if (p == 1)
						hold_requests++;
					// sender waits for every outstanding token
					if (p == 3)
						drain_results();
				end
				if ($urandom_range(99) < 15) begin
					repeat ($urandom_range(1, 6))
						send_req(req_type_t'($urandom_range(3)), byte_t'($urandom_range(255)));
				end else begin
					send_record();
				end
			end
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ csv_field_tokenizer_top.f @@
rtl/cft_pkg.sv
rtl/cft_req_if.sv
rtl/cft_res_if.sv
rtl/csv_field_tokenizer_top.sv
dv/cft_checker.sv
dv/tb_csv_field_tokenizer_top.sv
